[src/assert_macros.svh]
// assertion macros shared by the marker block
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLIES(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

[src/tnm_pkg.sv]
// types, constants and step functions of the triangle normal marker
// no dependencies; used by tnm_normal_unit and triangle_normal_marker
package tnm_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int COORD_WIDTH     = 32;
    localparam int NUM_COEF        = 12;
    localparam int PROD_SH_W       = 64 - FRAC_BITS;
    localparam int NORM_BITS       = 30;
    localparam int DIV3_SHIFT      = 35;
    localparam int STEPS_PER_STAGE = 4;
    localparam int SQRT_STEPS      = 32;
    localparam int SQRT_STAGES     = SQRT_STEPS / STEPS_PER_STAGE;
    localparam int DIV_STEPS       = 32;
    localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;
    localparam int FR_STAGES       = 10;

    localparam logic [30:0] MARKER_RESET = 31'((64'd1 << FRAC_BITS) / 5);
    localparam logic signed [31:0] COEF_ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [63:0] COORD_MAX = 64'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [63:0] COORD_MIN = -COORD_MAX - 64'sd1;
    localparam logic [33:0] DIV3_MUL = 34'(((64'd1 << DIV3_SHIFT) + 64'd1) / 3);

    typedef enum logic {
        OP_COEF_WRITE = 1'b0,
        OP_TRIANGLE   = 1'b1
    } op_t;

    typedef logic signed [31:0] coord_t;

    typedef struct packed {
        op_t        operation;
        logic [3:0] coef_index;
        coord_t     coef_value;
        coord_t     v0_x;
        coord_t     v0_y;
        coord_t     v0_z;
        coord_t     v1_x;
        coord_t     v1_y;
        coord_t     v1_z;
        coord_t     v2_x;
        coord_t     v2_y;
        coord_t     v2_z;
    } tnm_in_t;

    typedef struct packed {
        coord_t center_x;
        coord_t center_y;
        coord_t center_z;
        coord_t tip_x;
        coord_t tip_y;
        coord_t tip_z;
        logic   degenerate;
        logic   saturated;
    } tnm_out_t;

    // centroid, scaled normal and flags handed from front end to normal unit
    typedef struct packed {
        coord_t [2:0] cen;
        coord_t [2:0] cn;
        logic         degen;
        logic         sat;
    } tnm_norm_t;

    // front-end side data that rides along the cross product stages
    typedef struct packed {
        coord_t [2:0] cen;
        logic         degen;
        logic         sat;
    } tnm_side_t;

    typedef struct packed {
        logic   sat;
        coord_t val;
    } sat32_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic [31:0] den;
    } div_st_t;

    // clamp to the coordinate range, flag on clamp
    function automatic sat32_t clamp32(input logic signed [63:0] v);
        sat32_t r;
        r.sat = 1'b0;
        r.val = 32'(v);
        if (v > COORD_MAX)
        begin
            r.sat = 1'b1;
            r.val = 32'(COORD_MAX);
        end
        else if (v < COORD_MIN)
        begin
            r.sat = 1'b1;
            r.val = 32'(COORD_MIN);
        end
        return r;
    endfunction

    // one bit of the floor square root, remainder form
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t a, input int bit_pos);
        sqrt_st_t    r;
        logic [65:0] trial;
        trial = ({34'd0, a.root} << (bit_pos + 1)) + (66'd1 << (2 * bit_pos));
        r = a;
        if ({2'b00, a.rem} >= trial)
        begin
            r.rem  = a.rem - trial[63:0];
            r.root = a.root | (32'd1 << bit_pos);
        end
        return r;
    endfunction

    // one quotient bit of restoring division
    function automatic div_st_t div_step(input div_st_t a);
        div_st_t     r;
        logic [32:0] nr;
        nr = {a.rem[31:0], a.num[31]};
        r = a;
        r.num = {a.num[30:0], 1'b0};
        if (nr >= {1'b0, a.den})
        begin
            r.rem = nr - {1'b0, a.den};
            r.quo = {a.quo[30:0], 1'b1};
        end
        else
        begin
            r.rem = nr;
            r.quo = {a.quo[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[src/tnm_normal_unit.sv]
// normal unit: length of the scaled cross product, offset division, tip and clamp
// depends on tnm_pkg and assert_macros.svh
`include "assert_macros.svh"

module tnm_normal_unit
    import tnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tnm_norm_t   norm,
    input  logic        norm_valid,
    output logic        norm_stall,
    input  logic [30:0] marker,
    output tnm_out_t    result,
    output logic        result_valid,
    input  logic        result_stall
);

    localparam int SQ_FIRST  = 2;
    localparam int MUL_STG   = SQ_FIRST + SQRT_STAGES;
    localparam int DIV_FIRST = MUL_STG + 1;
    localparam int OUT_STG   = DIV_FIRST + DIV_STAGES;

    logic [OUT_STG:0] vld_reg;
    logic [OUT_STG:0] rdy;
    tnm_norm_t        side_reg [OUT_STG];
    logic [61:0]      sq_reg [3];
    sqrt_st_t         sqs_reg [SQRT_STAGES + 1];
    div_st_t          div_reg [DIV_STAGES + 1][3];
    tnm_out_t         result_reg;

    // stage handshake: a stage loads when empty or when its successor loads
    assign rdy[OUT_STG] = !vld_reg[OUT_STG] || !result_stall;
    for (genvar i = 0; i < OUT_STG; i++)
    begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i + 1];
    end
    assign norm_stall = !rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= norm_valid;
            for (int i = 1; i <= OUT_STG; i++)
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i - 1];
        end
    end

    // side data shift line
    always_ff @(posedge clk)
    begin
        if (rdy[0])
            side_reg[0] <= norm;
        for (int i = 1; i < OUT_STG; i++)
            if (rdy[i])
                side_reg[i] <= side_reg[i - 1];
    end

    // squares of the scaled normal
    logic signed [63:0] sq_full [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            sq_full[k] = $signed(norm.cn[k]) * $signed(norm.cn[k]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            for (int k = 0; k < 3; k++)
                sq_reg[k] <= sq_full[k][61:0];
    end

    // sum of squares seeds the root
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            sqs_reg[0].rem  <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            sqs_reg[0].root <= '0;
        end
    end

    // square root, a few result bits per stage
    for (genvar j = 1; j <= SQRT_STAGES; j++)
    begin : g_sqrt
        sqrt_st_t st [STEPS_PER_STAGE + 1];
        always_comb
        begin
            st[0] = sqs_reg[j - 1];
            for (int s = 0; s < STEPS_PER_STAGE; s++)
                st[s + 1] = sqrt_step(st[s],
                    SQRT_STEPS - 1 - (j - 1) * STEPS_PER_STAGE - s);
        end
        always_ff @(posedge clk)
        begin
            if (rdy[SQ_FIRST + j - 1])
                sqs_reg[j] <= st[STEPS_PER_STAGE];
        end
    end

    // normal component magnitudes times marker length, seed the dividers
    logic [31:0] len;
    logic [30:0] cmag [3];
    logic [63:0] num [3];
    always_comb
    begin
        len = (sqs_reg[SQRT_STAGES].root == '0) ? 32'd1 : sqs_reg[SQRT_STAGES].root;
        for (int k = 0; k < 3; k++)
        begin
            cmag[k] = side_reg[MUL_STG - 1].cn[k][31] ?
                31'(-$signed(side_reg[MUL_STG - 1].cn[k])) :
                31'(side_reg[MUL_STG - 1].cn[k]);
            num[k] = 64'(cmag[k]) * 64'(marker);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[MUL_STG])
            for (int k = 0; k < 3; k++)
            begin
                div_reg[0][k].rem <= {1'b0, num[k][63:32]};
                div_reg[0][k].num <= num[k][31:0];
                div_reg[0][k].quo <= '0;
                div_reg[0][k].den <= len;
            end
    end

    // three restoring dividers, a few quotient bits per stage
    for (genvar j = 1; j <= DIV_STAGES; j++)
    begin : g_div
        div_st_t dv [STEPS_PER_STAGE + 1][3];
        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                dv[0][k] = div_reg[j - 1][k];
                for (int s = 0; s < STEPS_PER_STAGE; s++)
                    dv[s + 1][k] = div_step(dv[s][k]);
            end
        end
        always_ff @(posedge clk)
        begin
            if (rdy[MUL_STG + j])
                for (int k = 0; k < 3; k++)
                    div_reg[j][k] <= dv[STEPS_PER_STAGE][k];
        end
    end

    // signed offset, tip and final clamp
    tnm_norm_t          fin;
    logic signed [32:0] qs [3];
    logic signed [32:0] off [3];
    sat32_t             tipc [3];
    coord_t             tip [3];
    logic               tsat;
    always_comb
    begin
        fin  = side_reg[OUT_STG - 1];
        tsat = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            qs[k]   = $signed({1'b0, div_reg[DIV_STAGES][k].quo});
            off[k]  = fin.cn[k][31] ? -qs[k] : qs[k];
            tipc[k] = clamp32(64'($signed(fin.cen[k])) + 64'(off[k]));
            if (fin.degen)
                tip[k] = fin.cen[k];
            else
            begin
                tip[k] = tipc[k].val;
                tsat   = tsat | tipc[k].sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[OUT_STG])
        begin
            result_reg.center_x   <= fin.cen[0];
            result_reg.center_y   <= fin.cen[1];
            result_reg.center_z   <= fin.cen[2];
            result_reg.tip_x      <= tip[0];
            result_reg.tip_y      <= tip[1];
            result_reg.tip_z      <= tip[2];
            result_reg.degenerate <= fin.degen;
            result_reg.saturated  <= fin.sat | tsat;
        end
    end

    assign result       = result_reg;
    assign result_valid = vld_reg[OUT_STG];

    // a degenerate face has its tip on the centroid
    `ASSERT_IMPLIES(a_degen_tip, result_valid && result.degenerate, result.tip_x == result.center_x && result.tip_y == result.center_y && result.tip_z == result.center_z)
    // a normal component never exceeds the length, so the offset stays within the marker
    `ASSERT_IMPLIES(a_quo_bound, vld_reg[OUT_STG - 1], div_reg[DIV_STAGES][0].quo <= 32'(marker))

endmodule

[src/triangle_normal_marker.sv]
// top level of the triangle normal marker: matrix store, transform, centroid, cross product
// depends on tnm_pkg, tnm_normal_unit and assert_macros.svh
//
//   channel   payload     handshake               direction
//   item      tnm_in_t    item_valid/item_stall   in
//   result    tnm_out_t   result_valid/result_stall out
//   marker    31 bits     marker_we               in, write only
//
// one triangle per cycle unless a stall holds the pipeline; a result passes through
// 10 front stages and 20 in the normal unit: 8 root stages and 8 divider stages
// a coefficient write only passes the first stage and gives no result
// reset sets the identity matrix and the default marker length; no clearing pass
// a stall holds each full stage; empty stages keep filling behind it
`include "assert_macros.svh"

module triangle_normal_marker
    import tnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tnm_in_t     item,
    input  logic        item_valid,
    output logic        item_stall,
    output tnm_out_t    result,
    output logic        result_valid,
    input  logic        result_stall,
    input  logic        marker_we,
    input  logic [30:0] marker_wdata
);

    logic [FR_STAGES-1:0] vld_reg;
    logic [FR_STAGES-1:0] rdy;
    logic                 norm_stall;
    logic [30:0]          marker_reg;
    coord_t               coef_reg [NUM_COEF];
    logic                 coef_wr_en;

    tnm_in_t                   s0_item_reg;
    logic signed [PROD_SH_W-1:0] s1_prod_reg [3][3][3];
    coord_t                    s1_trans_reg [3];
    coord_t                    s2_p_reg [3][3];
    logic                      s2_sat_reg;
    logic signed [33:0]        s3_csum_reg [3];
    logic signed [32:0]        s3_e_reg [2][3];
    logic                      s3_sat_reg;
    logic [31:0]               s4_cq_reg [3];
    logic                      s4_cneg_reg [3];
    coord_t                    s4_e_reg [2][3];
    logic                      s4_sat_reg;
    logic signed [63:0]        s5_xa_reg [3];
    logic signed [63:0]        s5_xb_reg [3];
    logic signed [63:0]        s6_c_reg [3];
    logic signed [63:0]        s7_c_reg [3];
    logic [62:0]               s7_mor_reg;
    logic signed [63:0]        s8_c_reg [3];
    logic [5:0]                s8_t_reg;
    coord_t                    s9_cn_reg [3];
    tnm_side_t                 side_reg [5:9];
    tnm_norm_t                 norm_data;

    // marker length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marker_reg <= MARKER_RESET;
        else if (marker_we)
            marker_reg <= marker_wdata;
    end

    // stage handshake; a coefficient write leaves the first stage at once
    assign rdy[FR_STAGES-1] = !vld_reg[FR_STAGES-1] || !norm_stall;
    for (genvar i = 1; i < FR_STAGES - 1; i++)
    begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i + 1];
    end
    assign rdy[0] = !vld_reg[0] || (s0_item_reg.operation == OP_COEF_WRITE) || rdy[1];
    assign item_stall = !rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= item_valid;
            if (rdy[1])
                vld_reg[1] <= vld_reg[0] && (s0_item_reg.operation == OP_TRIANGLE);
            for (int i = 2; i < FR_STAGES; i++)
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i - 1];
        end
    end

    // input stage
    always_ff @(posedge clk)
    begin
        if (rdy[0])
            s0_item_reg <= item;
    end

    // write of an in-range slot held in the first stage
    assign coef_wr_en = vld_reg[0] && s0_item_reg.operation == OP_COEF_WRITE
                        && s0_item_reg.coef_index < 4'(NUM_COEF);

    // matrix store, written in order as the write transaction passes the first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
                coef_reg[i] <= (i == 0 || i == 5 || i == 10) ? COEF_ONE : '0;
        end
        else if (coef_wr_en)
        begin
            coef_reg[s0_item_reg.coef_index] <= s0_item_reg.coef_value;
        end
    end

    // coefficient by coordinate products, floor shifted
    coord_t             vtx [3][3];
    logic signed [63:0] prod [3][3][3];
    always_comb
    begin
        vtx[0][0] = s0_item_reg.v0_x;
        vtx[0][1] = s0_item_reg.v0_y;
        vtx[0][2] = s0_item_reg.v0_z;
        vtx[1][0] = s0_item_reg.v1_x;
        vtx[1][1] = s0_item_reg.v1_y;
        vtx[1][2] = s0_item_reg.v1_z;
        vtx[2][0] = s0_item_reg.v2_x;
        vtx[2][1] = s0_item_reg.v2_y;
        vtx[2][2] = s0_item_reg.v2_z;
        for (int i = 0; i < 3; i++)
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    prod[i][r][k] = coef_reg[r * 4 + k] * vtx[i][k];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int i = 0; i < 3; i++)
                for (int r = 0; r < 3; r++)
                    for (int k = 0; k < 3; k++)
                        s1_prod_reg[i][r][k] <= PROD_SH_W'(prod[i][r][k] >>> FRAC_BITS);
            for (int r = 0; r < 3; r++)
                s1_trans_reg[r] <= coef_reg[r * 4 + 3];
        end
    end

    // row sums with translation, clamped
    sat32_t pc [3][3];
    logic   psat;
    always_comb
    begin
        psat = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int r = 0; r < 3; r++)
            begin
                pc[i][r] = clamp32(64'(s1_prod_reg[i][r][0]) + 64'(s1_prod_reg[i][r][1])
                    + 64'(s1_prod_reg[i][r][2]) + 64'(s1_trans_reg[r]));
                psat = psat | pc[i][r].sat;
            end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int i = 0; i < 3; i++)
                for (int r = 0; r < 3; r++)
                    s2_p_reg[i][r] <= pc[i][r].val;
            s2_sat_reg <= psat;
        end
    end

    // vertex sums and edges
    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_csum_reg[k] <= 34'(s2_p_reg[0][k]) + 34'(s2_p_reg[1][k])
                    + 34'(s2_p_reg[2][k]);
                s3_e_reg[0][k] <= 33'(s2_p_reg[1][k]) - 33'(s2_p_reg[0][k]);
                s3_e_reg[1][k] <= 33'(s2_p_reg[2][k]) - 33'(s2_p_reg[0][k]);
            end
            s3_sat_reg <= s2_sat_reg;
        end
    end

    // edge prescale and divide by three through the reciprocal
    logic [32:0] emag [2][3];
    logic        esh;
    logic [33:0] cmag [3];
    logic [67:0] cprod [3];
    always_comb
    begin
        esh = 1'b0;
        for (int j = 0; j < 2; j++)
            for (int k = 0; k < 3; k++)
            begin
                emag[j][k] = s3_e_reg[j][k][32] ? 33'(-s3_e_reg[j][k]) : 33'(s3_e_reg[j][k]);
                esh = esh | emag[j][k][32] | emag[j][k][31];
            end
        for (int k = 0; k < 3; k++)
        begin
            cmag[k]  = s3_csum_reg[k][33] ? 34'(-s3_csum_reg[k]) : 34'(s3_csum_reg[k]);
            cprod[k] = 68'(cmag[k]) * 68'(DIV3_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s4_cq_reg[k]   <= cprod[k][DIV3_SHIFT +: 32];
                s4_cneg_reg[k] <= s3_csum_reg[k][33];
                for (int j = 0; j < 2; j++)
                    s4_e_reg[j][k] <= esh ? 32'(s3_e_reg[j][k] >>> 1) : 32'(s3_e_reg[j][k]);
            end
            s4_sat_reg <= s3_sat_reg;
        end
    end

    // signed centroid and cross product terms
    logic signed [32:0] cqs [3];
    logic signed [32:0] cenv [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cqs[k]  = $signed({1'b0, s4_cq_reg[k]});
            cenv[k] = s4_cneg_reg[k] ? -cqs[k] : cqs[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            s5_xa_reg[0] <= s4_e_reg[0][1] * s4_e_reg[1][2];
            s5_xb_reg[0] <= s4_e_reg[0][2] * s4_e_reg[1][1];
            s5_xa_reg[1] <= s4_e_reg[0][2] * s4_e_reg[1][0];
            s5_xb_reg[1] <= s4_e_reg[0][0] * s4_e_reg[1][2];
            s5_xa_reg[2] <= s4_e_reg[0][0] * s4_e_reg[1][1];
            s5_xb_reg[2] <= s4_e_reg[0][1] * s4_e_reg[1][0];
            for (int k = 0; k < 3; k++)
                side_reg[5].cen[k] <= 32'(cenv[k]);
            side_reg[5].degen <= 1'b0;
            side_reg[5].sat   <= s4_sat_reg;
        end
    end

    // cross product and zero test
    logic signed [63:0] cx [3];
    tnm_side_t          s6_side;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            cx[k] = s5_xa_reg[k] - s5_xb_reg[k];
        s6_side       = side_reg[5];
        s6_side.degen = (cx[0] == '0) && (cx[1] == '0) && (cx[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            for (int k = 0; k < 3; k++)
                s6_c_reg[k] <= cx[k];
            side_reg[6] <= s6_side;
        end
    end

    // combined magnitude, its top bit sets the normalizing shift
    logic [63:0] cm [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            cm[k] = s6_c_reg[k][63] ? 64'(-s6_c_reg[k]) : 64'(s6_c_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            for (int k = 0; k < 3; k++)
                s7_c_reg[k] <= s6_c_reg[k];
            s7_mor_reg  <= cm[0][62:0] | cm[1][62:0] | cm[2][62:0];
            side_reg[7] <= side_reg[6];
        end
    end

    // shift count from the highest set bit
    logic [5:0] t_next;
    always_comb
    begin
        t_next = '0;
        for (int b = NORM_BITS; b < 63; b++)
            if (s7_mor_reg[b])
                t_next = 6'(b - NORM_BITS + 1);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            for (int k = 0; k < 3; k++)
                s8_c_reg[k] <= s7_c_reg[k];
            s8_t_reg    <= t_next;
            side_reg[8] <= side_reg[7];
        end
    end

    // scaled normal
    always_ff @(posedge clk)
    begin
        if (rdy[9])
        begin
            for (int k = 0; k < 3; k++)
                s9_cn_reg[k] <= 32'(s8_c_reg[k] >>> s8_t_reg);
            side_reg[9] <= side_reg[8];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            norm_data.cen[k] = side_reg[9].cen[k];
            norm_data.cn[k]  = s9_cn_reg[k];
        end
        norm_data.degen = side_reg[9].degen;
        norm_data.sat   = side_reg[9].sat;
    end

    tnm_normal_unit u_normal (
        .clk          (clk),
        .rst_n        (rst_n),
        .norm         (norm_data),
        .norm_valid   (vld_reg[FR_STAGES-1]),
        .norm_stall   (norm_stall),
        .marker       (marker_reg),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // the zero flag and a zero scaled normal go together
    `ASSERT_IMPLIES(a_norm_degen, vld_reg[FR_STAGES-1], norm_data.degen == (norm_data.cn == '0))
    // input stalls only behind a triangle held in the first stage
    `ASSERT_IMPLIES(a_stall_cause, item_stall, vld_reg[0] && s0_item_reg.operation == OP_TRIANGLE)
    // a coefficient write lands in its slot
    `ASSERT_NEXT(a_coef_write, coef_wr_en, coef_reg[$past(s0_item_reg.coef_index)] == $past(s0_item_reg.coef_value))

endmodule
